// ----- hdl/lzd_pkg.sv -----
package lzd_pkg;

	// Widths fixed by the stream format.
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 6;
	// A distance is at most 65535 + 1, so it needs seventeen bits.
	localparam int DIST_W = 17;

	// Where the parser stands in the compressed stream.
	typedef enum logic [1:0] {
		PH_CTRL,
		PH_LIT,
		PH_DIST_A,
		PH_DIST_B
	} phase_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIT,
		ST_CHECK,
		ST_BAD,
		ST_BASE,
		ST_READ,
		ST_COPY
	} seq_state_t;

	// Operations of the shared subtract unit.
	typedef enum logic {
		ALU_CMP,
		ALU_WRAP
	} alu_op_t;

	// One result word handed from the sequencer to the output register.
	typedef struct packed {
		logic              load;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              bad;
	} lzd_emit_t;

endpackage

// ----- hdl/lz_backref_decompressor_core.sv -----
// LZ back-reference decompressor. Compressed bytes enter on the s_axis side one
// word at a time and decompressed bytes leave on the m_axis side; tlast marks
// the last byte caused by one input word and tuser flags a match whose
// distance reaches past the bytes produced so far (one zero byte, and the match
// is dropped). Control and distance bytes give no output. A match does its range
// check (ST_CHECK) and start address (ST_BASE) in the shared subtractor, then
// copies up to 64 bytes, each read on the history memory's registered read port
// (ST_READ) and written back as it is sent (ST_COPY). Input is not taken while an
// item is being worked on; output back-pressure stalls the output states. The
// history window holds WINDOW_DEPTH bytes and needs no clearing after reset.
module lz_backref_decompressor_core
	import lzd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic       m_axis_tuser   // [0] bad_reference
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	lzd_emit_t         emit;
	logic              out_free;
	logic              out_valid_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;

	lzd_seq #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.out_free (out_free),
		.rd_data  (mem_rdata),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.emit     (emit)
	);

	lzd_history #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// The output register may be loaded when empty or being emptied.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			m_axis_tdata <= emit.data;
			m_axis_tlast <= emit.last;
			m_axis_tuser <= emit.bad;
		end
	end

endmodule

// ----- hdl/lzd_alu.sv -----
module lzd_alu
	import lzd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 65536
) (
	input  alu_op_t           op,
	input  logic [DIST_W-1:0] a,
	input  logic [DIST_W-1:0] b,
	output logic [DIST_W-1:0] res,
	output logic              borrow
);

	logic [DIST_W:0] diff;

	// One subtractor serves both the range check and the start address.
	assign diff   = {1'b0, a} - {1'b0, b};
	assign borrow = diff[DIST_W];

	// In wrap mode a negative difference is folded back into the window.
	always_comb begin
		if (op == ALU_WRAP && borrow) begin
			res = diff[DIST_W-1:0] + DIST_W'(WINDOW_DEPTH);
		end else begin
			res = diff[DIST_W-1:0];
		end
	end

endmodule

// ----- hdl/lzd_history.sv -----
module lzd_history
	import lzd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 65536,
	localparam int AW = $clog2(WINDOW_DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [WINDOW_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/lzd_seq.sv -----
module lzd_seq
	import lzd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 65536,
	localparam int AW = $clog2(WINDOW_DEPTH),
	localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              out_free,
	input  logic [BYTE_W-1:0] rd_data,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [BYTE_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	output lzd_emit_t         emit
);

	seq_state_t        state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [7:0]        lit_left_q, lit_left_d;
	logic [6:0]        match_ctl_q, match_ctl_d;
	logic [7:0]        dist_hi_q, dist_hi_d;
	logic [DIST_W-1:0] dist_q, dist_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [BYTE_W-1:0] byte_q, byte_d;
	logic [AW-1:0]     wp_q, rd_q, rd_d, rd_next, wp_next;
	logic [CW-1:0]     prod_q;
	logic              wr_step;

	alu_op_t           alu_op;
	logic [DIST_W-1:0] alu_a, alu_res;
	logic              alu_borrow;

	lzd_alu #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (dist_q),
		.res   (alu_res),
		.borrow(alu_borrow)
	);

	// Pointer steps that wrap at the end of the window.
	assign rd_next = (rd_q == AW'(WINDOW_DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign wp_next = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;

	// History ports: writes always go to the write pointer.
	assign mem_waddr = wp_q;
	assign mem_raddr = rd_q;
	assign mem_wdata = (state_q == ST_COPY) ? rd_data : byte_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, parser updates and strobes.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		lit_left_d  = lit_left_q;
		match_ctl_d = match_ctl_q;
		dist_hi_d   = dist_hi_q;
		dist_d      = dist_q;
		count_d     = count_q;
		byte_d      = byte_q;
		rd_d        = rd_q;
		in_ready    = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		wr_step     = 1'b0;
		emit        = '0;
		alu_op      = ALU_CMP;
		alu_a       = DIST_W'(prod_q);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (phase_q)
						PH_CTRL: begin
							if (in_byte[7]) begin
								match_ctl_d = in_byte[6:0];
								phase_d     = PH_DIST_A;
							end else begin
								lit_left_d = in_byte + 8'd1;
								phase_d    = PH_LIT;
							end
						end
						PH_LIT: begin
							byte_d = in_byte;
							if (lit_left_q != 8'd0) begin
								lit_left_d = lit_left_q - 8'd1;
							end
							if (lit_left_q <= 8'd1) begin
								phase_d = PH_CTRL;
							end
							state_d = ST_LIT;
						end
						PH_DIST_A: begin
							if (match_ctl_q[6]) begin
								dist_d  = DIST_W'(in_byte) + DIST_W'(1);
								phase_d = PH_CTRL;
								state_d = ST_CHECK;
							end else begin
								dist_hi_d = in_byte;
								phase_d   = PH_DIST_B;
							end
						end
						default: begin
							dist_d  = DIST_W'({dist_hi_q, in_byte}) + DIST_W'(1);
							phase_d = PH_CTRL;
							state_d = ST_CHECK;
						end
					endcase
				end
			end
			ST_LIT: begin
				if (out_free) begin
					emit.load = 1'b1;
					emit.data = byte_q;
					emit.last = 1'b1;
					mem_we    = 1'b1;
					wr_step   = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_CHECK: begin
				// A borrow means the distance reaches past the bytes produced.
				alu_op  = ALU_CMP;
				alu_a   = DIST_W'(prod_q);
				count_d = match_ctl_q[LEN_W-1:0];
				state_d = alu_borrow ? ST_BAD : ST_BASE;
			end
			ST_BAD: begin
				if (out_free) begin
					emit.load = 1'b1;
					emit.last = 1'b1;
					emit.bad  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_BASE: begin
				alu_op  = ALU_WRAP;
				alu_a   = DIST_W'(wp_q);
				rd_d    = alu_res[AW-1:0];
				state_d = ST_READ;
			end
			ST_READ: begin
				mem_re  = 1'b1;
				rd_d    = rd_next;
				state_d = ST_COPY;
			end
			ST_COPY: begin
				// The copied byte is written back before the next read.
				if (out_free) begin
					emit.load = 1'b1;
					emit.data = rd_data;
					emit.last = (count_q == '0);
					mem_we    = 1'b1;
					wr_step   = 1'b1;
					if (count_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						count_d = count_q - 1'b1;
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Parser state and window pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CTRL;
			lit_left_q  <= '0;
			match_ctl_q <= '0;
			dist_hi_q   <= '0;
			wp_q        <= '0;
			prod_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			lit_left_q  <= lit_left_d;
			match_ctl_q <= match_ctl_d;
			dist_hi_q   <= dist_hi_d;
			if (wr_step) begin
				wp_q <= wp_next;
				if (prod_q != CW'(WINDOW_DEPTH)) begin
					prod_q <= prod_q + 1'b1;
				end
			end
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		dist_q  <= dist_d;
		count_q <= count_d;
		byte_q  <= byte_d;
		rd_q    <= rd_d;
	end

endmodule

// ----- hdl/lzd_checker.sv -----
module lzd_assertions (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);

	// A bad reference is always a single, final word.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("bad reference word without tlast");

	// A bad reference carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
		else $error("bad reference word with non-zero data");

	// While a word from the middle of a match copy is on offer, no input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input accepted during a match copy");

	// A stalled output word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("output word changed while stalled");

endmodule

bind lz_backref_decompressor_core lzd_assertions u_lzd_assertions (.*);

// ----- tb/lzd_checker.sv -----
module lzd_checker
	import lzd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,  // [7:0] out_byte
	input  logic       m_tlast,
	input  logic       m_tuser,  // [0] bad_reference
	output int         failures,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// One decompressed word as it should leave the block.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              bad;
	} out_word_t;

	out_word_t         expected_bytes[$];

	// Our own copy of the parser state and the history window.
	logic [BYTE_W-1:0] window [WINDOW_DEPTH];
	phase_t            phase;
	int                lit_left;
	logic [6:0]        match_ctrl;
	logic [7:0]        dist_hi;
	int                wr_ptr;
	int                produced;

	task automatic report_error(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		failures++;
	endtask

	// Adds one expected word at the tail of the queue.
	task automatic queue_word(input logic [7:0] byte_val, input logic is_last,
		input logic is_bad);
		out_word_t w;
		w = '{data: byte_val, last: is_last, bad: is_bad};
		expected_bytes.insert(expected_bytes.size(), w);
	endtask

	// Appends one byte to the history, as every good output byte does.
	task automatic store_byte(input logic [7:0] b);
		window[wr_ptr] = b;
		wr_ptr = (wr_ptr + 1 == WINDOW_DEPTH) ? 0 : wr_ptr + 1;
		if (produced < WINDOW_DEPTH)
			produced++;
	endtask

	// Copies a match out of the history; each copied byte is written back at once,
	// so a distance shorter than the length repeats bytes.
	task automatic copy_back(input int back_dist);
		int len;
		int rd;
		logic [7:0] b;
		len = int'(match_ctrl[5:0]) + 1;
		if (back_dist > produced || back_dist > WINDOW_DEPTH) begin
			queue_word(8'h00, 1'b1, 1'b1);
			return;
		end
		rd = (wr_ptr >= back_dist) ? wr_ptr - back_dist : wr_ptr + WINDOW_DEPTH - back_dist;
		for (int i = 0; i < len; i++) begin
			b = window[rd];
			store_byte(b);
			queue_word(b, (i + 1 == len), 1'b0);
			rd = (rd + 1 == WINDOW_DEPTH) ? 0 : rd + 1;
		end
	endtask

	// Advances the parser by one compressed byte and queues what it produces.
	task automatic decode_byte(input logic [7:0] b);
		case (phase)
			PH_CTRL: begin
				if (b[7]) begin
					match_ctrl = b[6:0];
					phase = PH_DIST_A;
				end else begin
					lit_left = int'(b) + 1;
					phase = PH_LIT;
				end
			end
			PH_LIT: begin
				store_byte(b);
				queue_word(b, 1'b1, 1'b0);
				if (lit_left > 0)
					lit_left--;
				if (lit_left == 0)
					phase = PH_CTRL;
			end
			PH_DIST_A: begin
				if (match_ctrl[6]) begin
					phase = PH_CTRL;
					copy_back(int'(b) + 1);
				end else begin
					dist_hi = b;
					phase = PH_DIST_B;
				end
			end
			default: begin
				phase = PH_CTRL;
				copy_back(int'({dist_hi, b}) + 1);
			end
		endcase
	endtask

	// Predict on every accepted input word, then check every accepted output word.
	always @(posedge clk or negedge arst_n) begin
		out_word_t got;
		out_word_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			phase = PH_CTRL;
			lit_left = 0;
			match_ctrl = '0;
			dist_hi = '0;
			wr_ptr = 0;
			produced = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				got = '{data: m_tdata, last: m_tlast, bad: m_tuser};
				if (expected_bytes.size() == 0) begin
					report_error($sformatf("unexpected word: byte %02h last %0b bad %0b",
						got.data, got.last, got.bad));
				end else begin
					want = expected_bytes.pop_front();
					if (got.data !== want.data)
						report_error($sformatf("out_byte is %02h, should be %02h",
							got.data, want.data));
					if (got.last !== want.last)
						report_error($sformatf("run_last is %0b, should be %0b",
							got.last, want.last));
					if (got.bad !== want.bad)
						report_error($sformatf("bad_reference is %0b, should be %0b",
							got.bad, want.bad));
				end
			end
			pending <= expected_bytes.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW     = 65536;
	localparam int ITEMS      = 400;
	localparam int IDLE_LIMIT = 5000;

	// Ways in which the receiver takes words.
	localparam int RX_ALWAYS   = 0;
	localparam int RX_RANDOM   = 1;
	localparam int RX_PERIODIC = 2;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       m_axis_tuser;

	int failures;
	int pending;
	int items_sent = 0;
	int produced_est = 0;
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;
	int rx_mode = RX_ALWAYS;
	int rx_left = 0;
	int rx_period = 2;
	int rx_tick = 0;

	lz_backref_decompressor_core #(
		.WINDOW_DEPTH(WINDOW)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	lzd_checker #(
		.WINDOW_DEPTH(WINDOW)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata (s_axis_tdata),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata (m_axis_tdata),
		.m_tlast (m_axis_tlast),
		.m_tuser (m_axis_tuser),
		.failures(failures),
		.pending (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver switches now and then between taking every word, taking words
	// at random and being ready at a random regular period.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
			rx_period = $urandom_range(2, 7);
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS: m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
			default:   m_axis_tready <= (rx_tick % rx_period == 0);
		endcase
	end

	// Ends the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("lz_backref_decompressor_core: mismatch");
				$finish;
			end
		end
	end

	// Offers one word and returns at the falling edge after it was taken. Words
	// go out in bursts, with a gap of random length before each burst.
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
		end
		while (gap_left > 0) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
			gap_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	// A literal run of len_m1 + 1 random bytes.
	task automatic send_literals(input int len_m1);
		send_byte(8'(len_m1));
		for (int i = 0; i <= len_m1; i++)
			send_byte(8'($urandom_range(0, 255)));
		produced_est = (produced_est + len_m1 + 1 > WINDOW) ? WINDOW : produced_est + len_m1 + 1;
	endtask

	// A match of len_m1 + 1 bytes at the given distance, with a one-byte or a
	// two-byte distance field.
	task automatic send_match(input logic [5:0] len_m1, input logic short_dist,
		input int back_dist);
		logic [16:0] code;
		code = 17'(back_dist - 1);
		send_byte({1'b1, short_dist, len_m1});
		if (!short_dist)
			send_byte(code[15:8]);
		send_byte(code[7:0]);
		if (back_dist <= produced_est)
			produced_est = (produced_est + int'(len_m1) + 1 > WINDOW) ? WINDOW :
				produced_est + int'(len_m1) + 1;
	endtask

	initial begin
		int pick;
		int max_d;
		int back_dist;
		logic short_dist;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Two short literal runs, with the smallest and largest byte values.
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hff);
		send_byte(8'h5a);
		produced_est = 3;
		// Single-byte copy, then longest copies that overlap their own output,
		// with one-byte and two-byte distances.
		send_match(6'd0, 1'b1, 1);
		send_match(6'd63, 1'b1, 2);
		send_match(6'd63, 1'b0, 3);
		// Distances past the bytes produced, up to the largest that can be coded.
		send_match(6'd5, 1'b1, 256);
		send_match(6'd0, 1'b0, WINDOW);
		// A distance equal to the bytes produced, and one just beyond it.
		send_match(6'd4, 1'b0, produced_est);
		send_match(6'd2, 1'b1, produced_est + 1);
		// Longest literal run.
		send_literals(127);

		// Mostly well-formed runs and reachable matches, some matches at random
		// distances that may fall outside the history.
		while (items_sent < ITEMS) begin
			pick = $urandom_range(0, 99);
			short_dist = 1'($urandom_range(0, 1));
			if (pick < 45 || produced_est == 0) begin
				send_literals(($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) :
					$urandom_range(0, 7));
			end else if (pick < 85) begin
				max_d = produced_est;
				if (short_dist && max_d > 256)
					max_d = 256;
				if ($urandom_range(0, 1))
					back_dist = $urandom_range(1, (max_d < 8) ? max_d : 8);
				else
					back_dist = $urandom_range(1, max_d);
				send_match(6'($urandom_range(0, 63)), short_dist, back_dist);
			end else begin
				back_dist = short_dist ? $urandom_range(1, 256) : $urandom_range(1, WINDOW);
				send_match(6'($urandom_range(0, 63)), short_dist, back_dist);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("lz_backref_decompressor_core: match");
		else
			$display("lz_backref_decompressor_core: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/lzd_pkg.sv
hdl/lzd_alu.sv
hdl/lzd_history.sv
hdl/lzd_seq.sv
hdl/lz_backref_decompressor_core.sv
hdl/lzd_checker.sv
tb/lzd_checker.sv
tb/tb.sv
